[rtl/core/sorted_key_table_with_histogram_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key table
// Clocked assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_WITH_HISTOGRAM_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_WITH_HISTOGRAM_UNIT_MACROS_SVH

`ifndef SYNTH
// assertion that is off while reset is high
`define SKT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assertion that also runs through reset
`define SKT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKT_ASSERT(label, clk, rst, prop, msg)
`define SKT_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

[rtl/core/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// Types, constants and the grade-to-bin function of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_W           = 27;
   localparam int GRADE_W         = 10;
   localparam int BIN_NUM         = 10;
   localparam int BIN_TOP         = 9;
   localparam int BIN_IDX_W       = 4;
   localparam int OUT_CNT_W       = 7;
   localparam int BIN_STEP        = 100;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic               has_grade;
      logic [GRADE_W-1:0] grade;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // controller to datapath
   typedef struct packed {
      logic load;
      logic srch_issue;
      logic srch_update;
      logic chk_issue;
      logic chk_eval;
      logic shift_step;
      logic write_rec;
      logic commit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic srch_done;
      logic found;
      logic op_delete;
      logic is_full;
      logic needs_shift;
      logic shift_more;
   } ctl_status_type;

   // integer part of a grade in hundredths, clamped to the top bin
   function automatic logic [BIN_IDX_W-1:0] bin_of(input logic [GRADE_W-1:0] grade);
      logic [BIN_IDX_W-1:0] b;
      b = '0;
      for (int k = 1; k <= BIN_TOP; k++) begin
         if (grade >= GRADE_W'(k * BIN_STEP)) begin
            b = BIN_IDX_W'(k);
         end
      end
      return b;
   endfunction

endpackage

[rtl/core/sorted_key_table_with_histogram_unit.sv]
// Sequence: the search makes at most ceil(log2(n+1)) probes for n records;
//   the later records are then shifted when needed, and an insert writes
//   its record. A new transaction is accepted only once busy is low; busy
//   drops in the strobe cycle. Receiver cannot stall.
// Reset: synchronous, active high; clears count and bins, not the record RAM.
// ----------------------------------------------------------------------------
// sorted_key_table_with_histogram_unit
// Sorted record table with binary search insert/delete and a 10-bin grade
// histogram; controller and datapath with a RAM based record store.
// ----------------------------------------------------------------------------
module sorted_key_table_with_histogram_unit #(
   parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request transaction: accepted when start is high and busy is low
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [skt_pkg::KEY_W-1:0]         req_key,
   input  logic                              req_has_grade,
   input  logic [skt_pkg::GRADE_W-1:0]       req_grade,
   // response transaction: one cycle strobe, no back pressure
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic                              rsp_table_full,
   output logic [skt_pkg::OUT_CNT_W-1:0]     rsp_entry_count,
   output logic                              rsp_bin_changed,
   output logic [skt_pkg::BIN_IDX_W-1:0]     rsp_bin_index,
   output logic [skt_pkg::OUT_CNT_W-1:0]     rsp_bin_count
);

   // command and status between sequencer and datapath
   skt_pkg::ctl_cmd_type    cmd;
   skt_pkg::ctl_status_type status;

   // Sequencer: search probes (read, compare), check of the found position,
   // shift of the later records (pipelined read ahead / write behind),
   // record write for an insert, then commit of count and histogram.
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: record RAM, search bounds, shift pointers, bins, result regs.
   // An insert of a held key reports found and changes nothing; an insert
   // of a new key into a full table is refused with table_full set.
   skt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_has_grade   (req_has_grade),
      .req_grade       (req_grade),
      .rsp_found       (rsp_found),
      .rsp_table_full  (rsp_table_full),
      .rsp_entry_count (rsp_entry_count),
      .rsp_bin_changed (rsp_bin_changed),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_bin_count   (rsp_bin_count)
   );

endmodule

[rtl/core/skt_ram.sv]
// ----------------------------------------------------------------------------
// skt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/skt_ctrl.sv]
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: search, position check, shift, write and commit of a transaction.
// ----------------------------------------------------------------------------
`include "sorted_key_table_with_histogram_unit_macros.svh"

module skt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  skt_pkg::ctl_status_type status,
   output skt_pkg::ctl_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   typedef enum logic [2:0] {
      IDLE,
      SRCH_RD,
      SRCH_CMP,
      CHK_RD,
      CHK_EVAL,
      SHIFT,
      WRITE,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = SRCH_RD;
            end
         end
         SRCH_RD: begin
            if (status.srch_done) begin
               state_in = CHK_RD;
            end else begin
               cmd.srch_issue = 1'b1;
               state_in       = SRCH_CMP;
            end
         end
         SRCH_CMP: begin
            cmd.srch_update = 1'b1;
            state_in        = SRCH_RD;
         end
         CHK_RD: begin
            cmd.chk_issue = 1'b1;
            state_in      = CHK_EVAL;
         end
         CHK_EVAL: begin
            cmd.chk_eval = 1'b1;
            if (status.op_delete) begin
               if (status.found && status.needs_shift) begin
                  state_in = SHIFT;
               end else begin
                  state_in = FINISH;
               end
            end else if (status.found || status.is_full) begin
               state_in = FINISH;
            end else if (status.needs_shift) begin
               state_in = SHIFT;
            end else begin
               state_in = WRITE;
            end
         end
         SHIFT: begin
            cmd.shift_step = 1'b1;
            if (!status.shift_more) begin
               state_in = status.op_delete ? FINISH : WRITE;
            end
         end
         WRITE: begin
            cmd.write_rec = 1'b1;
            state_in      = FINISH;
         end
         FINISH: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SKT_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept did not raise busy")
   `SKT_ASSERT(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "strobe while busy")
   `SKT_ASSERT(a_rsp_once, clock, reset, rsp_valid |=> !rsp_valid, "strobe held two cycles")
   `SKT_ASSERT_NR(a_reset_idle, clock, reset |=> (!busy && !rsp_valid), "not idle after reset")

endmodule

[rtl/core/skt_datapath.sv]
// ----------------------------------------------------------------------------
// skt_datapath
// Record store, search bounds, shift pointers, histogram and result registers.
// ----------------------------------------------------------------------------
`include "sorted_key_table_with_histogram_unit_macros.svh"

module skt_datapath #(
   parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  skt_pkg::ctl_cmd_type              cmd,
   output skt_pkg::ctl_status_type           status,
   input  logic                              req_op,
   input  logic [skt_pkg::KEY_W-1:0]         req_key,
   input  logic                              req_has_grade,
   input  logic [skt_pkg::GRADE_W-1:0]       req_grade,
   output logic                              rsp_found,
   output logic                              rsp_table_full,
   output logic [skt_pkg::OUT_CNT_W-1:0]     rsp_entry_count,
   output logic                              rsp_bin_changed,
   output logic [skt_pkg::BIN_IDX_W-1:0]     rsp_bin_index,
   output logic [skt_pkg::OUT_CNT_W-1:0]     rsp_bin_count
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   // latched request
   logic                        op_ff;
   logic [skt_pkg::KEY_W-1:0]   key_ff;
   logic                        hasg_ff;
   logic [skt_pkg::GRADE_W-1:0] grade_ff;

   // search and shift
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;

   // check result of the located entry
   logic                        found_ff;
   logic                        old_hasg_ff;
   logic [skt_pkg::GRADE_W-1:0] old_grade_ff;
   logic                        found_now;

   // state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] bins_ff [skt_pkg::BIN_NUM];

   // RAM port
   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [skt_pkg::REC_W-1:0] wr_data, rd_data;
   skt_pkg::rec_type         rd_rec, new_rec;

   // commit
   logic                           ins_ok, del_ok, is_full, chg;
   logic [skt_pkg::BIN_IDX_W-1:0]  bin_sel;
   logic [CNT_W-1:0]               bin_cur, bin_new;

   // result registers
   logic                           rsp_found_ff, rsp_full_ff, rsp_chg_ff;
   logic [skt_pkg::OUT_CNT_W-1:0]  rsp_count_ff, rsp_bcnt_ff;
   logic [skt_pkg::BIN_IDX_W-1:0]  rsp_bidx_ff;

   assign rd_rec  = skt_pkg::rec_type'(rd_data);
   assign new_rec = '{key: key_ff, has_grade: hasg_ff, grade: grade_ff};
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign is_full = (count_ff == DEPTH_C);
   assign found_now = (lo_ff < count_ff) && (rd_rec.key == key_ff);

   assign status.srch_done   = (lo_ff >= hi_ff);
   assign status.found       = found_now;
   assign status.op_delete   = (op_ff == skt_pkg::OP_DELETE);
   assign status.is_full     = is_full;
   assign status.needs_shift = (op_ff == skt_pkg::OP_DELETE) ?
                               ((count_ff - lo_ff) > ONE_C) : (count_ff != lo_ff);
   assign status.shift_more  = (rem_ff != '0);

   // bounds, pointers and RAM port
   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rd_en        = 1'b0;
      rd_addr      = lo_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = lo_ff[AW-1:0];
      wr_data      = new_rec;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.srch_issue) begin
         rd_en   = 1'b1;
         rd_addr = mid[AW-1:0];
      end
      if (cmd.srch_update) begin
         if (rd_rec.key < key_ff) begin
            lo_in = mid_ff + ONE_C;
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.chk_issue) begin
         rd_en   = 1'b1;
         rd_addr = lo_ff[AW-1:0];
      end
      if (cmd.chk_eval) begin
         pend_in = 1'b0;
         if (op_ff == skt_pkg::OP_DELETE) begin
            ptr_in = lo_ff + ONE_C;
            rem_in = count_ff - lo_ff - ONE_C;
         end else begin
            ptr_in = count_ff - ONE_C;
            rem_in = count_ff - lo_ff;
         end
      end
      if (cmd.shift_step) begin
         // read one entry ahead, write the one read last cycle
         if (pend_ff) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_ff;
            wr_data = rd_data;
         end
         if (rem_ff != '0) begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff[AW-1:0];
            rem_in  = rem_ff - ONE_C;
            pend_in = 1'b1;
            if (op_ff == skt_pkg::OP_DELETE) begin
               ptr_in       = ptr_ff + ONE_C;
               pend_addr_in = ptr_ff[AW-1:0] - AW'(1);
            end else begin
               ptr_in       = ptr_ff - ONE_C;
               pend_addr_in = ptr_ff[AW-1:0] + AW'(1);
            end
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.write_rec) begin
         wr_en   = 1'b1;
         wr_addr = lo_ff[AW-1:0];
         wr_data = new_rec;
      end
   end

   // commit of count and histogram
   always_comb begin
      ins_ok  = (op_ff == skt_pkg::OP_INSERT) && !found_ff && !is_full;
      del_ok  = (op_ff == skt_pkg::OP_DELETE) && found_ff;
      bin_sel = ins_ok ? skt_pkg::bin_of(grade_ff) : skt_pkg::bin_of(old_grade_ff);
      chg     = (ins_ok && hasg_ff) || (del_ok && old_hasg_ff);
      bin_cur = bins_ff[bin_sel];
      if (ins_ok) begin
         bin_new = bin_cur + ONE_C;
      end else if (bin_cur != '0) begin
         bin_new = bin_cur - ONE_C;
      end else begin
         bin_new = bin_cur;
      end
      if (ins_ok) begin
         count_in = count_ff + ONE_C;
      end else if (del_ok) begin
         count_in = count_ff - ONE_C;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         for (int b = 0; b < skt_pkg::BIN_NUM; b++) begin
            bins_ff[b] <= '0;
         end
      end else begin
         pend_ff <= pend_in;
         if (cmd.commit) begin
            count_ff <= count_in;
            if (chg) begin
               bins_ff[bin_sel] <= bin_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         key_ff   <= req_key;
         hasg_ff  <= req_has_grade;
         grade_ff <= req_grade;
      end
      if (cmd.srch_issue) begin
         mid_ff <= mid;
      end
      if (cmd.chk_eval) begin
         found_ff     <= found_now;
         old_hasg_ff  <= rd_rec.has_grade;
         old_grade_ff <= rd_rec.grade;
      end
      if (cmd.commit) begin
         rsp_found_ff <= found_ff;
         rsp_full_ff  <= (op_ff == skt_pkg::OP_INSERT) && !found_ff && is_full;
         rsp_count_ff <= skt_pkg::OUT_CNT_W'(count_in);
         rsp_chg_ff   <= chg;
         rsp_bidx_ff  <= chg ? bin_sel : '0;
         rsp_bcnt_ff  <= chg ? skt_pkg::OUT_CNT_W'(bin_new) : '0;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      pend_addr_ff <= pend_addr_in;
   end

   skt_ram #(
      .WIDTH (skt_pkg::REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_found       = rsp_found_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_bin_changed = rsp_chg_ff;
   assign rsp_bin_index   = rsp_bidx_ff;
   assign rsp_bin_count   = rsp_bcnt_ff;

   `SKT_ASSERT(a_no_rw_clash, clock, reset, (wr_en && rd_en) |-> (wr_addr != rd_addr), "shift read hits write address")
   `SKT_ASSERT(a_count_range, clock, reset, cmd.commit |=> (count_ff <= DEPTH_C), "entry count above depth")

endmodule

[dv/sorted_key_table_with_histogram_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_with_histogram_unit_test
// Self-checking bench for the sorted key table: a queue-fed command driver, a
// response monitor and a shadow table/histogram that predicts every response.
// ----------------------------------------------------------------------------
module sorted_key_table_with_histogram_unit_test;

   localparam int DEPTH          = skt_pkg::TABLE_DEPTH_DEF;
   localparam int KEY_TOP        = 99999999;
   localparam int GRADE_TOP      = 1000;
   localparam int POOL_SIZE      = 128;
   localparam int RANDOM_OPS     = 1785;
   localparam int WATCHDOG_LIMIT = 4000;  // idle cycles before the run is stopped
   localparam int DRAIN_CYCLES   = 120;   // cycles run on after the last expected response
   localparam int REPORT_MAX     = 10;

   // one command transaction
   typedef struct packed {
      logic                        op;
      logic [skt_pkg::KEY_W-1:0]   key;
      logic                        has_grade;
      logic [skt_pkg::GRADE_W-1:0] grade;
   } table_op_type;

   // one response transaction
   typedef struct packed {
      logic                          found;
      logic                          table_full;
      logic [skt_pkg::OUT_CNT_W-1:0] entry_count;
      logic                          bin_changed;
      logic [skt_pkg::BIN_IDX_W-1:0] bin_index;
      logic [skt_pkg::OUT_CNT_W-1:0] bin_count;
   } table_rsp_type;

   // shadow copy of one stored record
   typedef struct packed {
      logic [skt_pkg::KEY_W-1:0]   key;
      logic                        graded;
      logic [skt_pkg::GRADE_W-1:0] grade;
   } held_rec_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_op = skt_pkg::OP_INSERT;
   logic [skt_pkg::KEY_W-1:0]     req_key = '0;
   logic                          req_has_grade = 1'b0;
   logic [skt_pkg::GRADE_W-1:0]   req_grade = '0;
   logic                          rsp_valid;
   logic                          rsp_found;
   logic                          rsp_table_full;
   logic [skt_pkg::OUT_CNT_W-1:0] rsp_entry_count;
   logic                          rsp_bin_changed;
   logic [skt_pkg::BIN_IDX_W-1:0] rsp_bin_index;
   logic [skt_pkg::OUT_CNT_W-1:0] rsp_bin_count;

   sorted_key_table_with_histogram_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_has_grade  (req_has_grade),
      .req_grade      (req_grade),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_table_full (rsp_table_full),
      .rsp_entry_count(rsp_entry_count),
      .rsp_bin_changed(rsp_bin_changed),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_bin_count  (rsp_bin_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow table and histogram
   // ------------------------------------------------------------------
   held_rec_type  held [DEPTH];
   int            held_count;
   int            grade_hist [skt_pkg::BIN_NUM];
   table_rsp_type expected_rsp [$];
   table_op_type  pending_ops [$];

   // coverage tallies for the closing summary
   int n_inserts, n_repeats, n_refused, n_deletes, n_absent, n_bin_moves;
   int peak_count, n_checked;

   int  error_count;
   int  idle_cycles;
   bit  req_taken;

   // integer part of a grade in hundredths; 9.00 and above all land in bin 9
   function automatic int grade_bin(logic [skt_pkg::GRADE_W-1:0] g);
      return (g >= 900) ? 9 : int'(g) / 100;
   endfunction

   // apply one command to the shadow state and return the response it causes
   function automatic table_rsp_type predict_table_op(table_op_type t);
      table_rsp_type r;
      int lo, hi, mid, slot, b;
      bit hit;
      r  = '0;
      lo = 0;
      hi = held_count;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (held[mid].key < t.key) lo = mid + 1;
         else hi = mid;
      end
      slot = lo;
      hit  = (slot < held_count) && (held[slot].key == t.key);
      r.found = hit;
      if (t.op == skt_pkg::OP_INSERT) begin
         n_inserts++;
         if (hit) begin
            n_repeats++;
         end else if (held_count >= DEPTH) begin
            // new key, no room: refused, nothing moves
            r.table_full = 1'b1;
            n_refused++;
         end else begin
            for (int i = held_count; i > slot; i--) held[i] = held[i-1];
            held[slot] = '{key: t.key, graded: t.has_grade, grade: t.grade};
            held_count++;
            if (t.has_grade) begin
               b = grade_bin(t.grade);
               grade_hist[b]++;
               r.bin_changed = 1'b1;
               r.bin_index   = skt_pkg::BIN_IDX_W'(b);
               r.bin_count   = skt_pkg::OUT_CNT_W'(grade_hist[b]);
            end
         end
      end else begin
         n_deletes++;
         if (!hit) begin
            n_absent++;
         end else begin
            if (held[slot].graded) begin
               b = grade_bin(held[slot].grade);
               if (grade_hist[b] > 0) grade_hist[b]--;  // saturate at zero
               r.bin_changed = 1'b1;
               r.bin_index   = skt_pkg::BIN_IDX_W'(b);
               r.bin_count   = skt_pkg::OUT_CNT_W'(grade_hist[b]);
            end
            for (int i = slot; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
         end
      end
      if (r.bin_changed) n_bin_moves++;
      if (held_count > peak_count) peak_count = held_count;
      r.entry_count = skt_pkg::OUT_CNT_W'(held_count);
      return r;
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------
   logic [skt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

   // grades cluster on bin edges, the top value included
   function automatic int pick_grade();
      int g;
      case ($urandom_range(0, 3))
         0: g = 100 * $urandom_range(0, 10);
         1: g = 100 * $urandom_range(1, 10) - 1;
         2: g = GRADE_TOP;
         default: g = $urandom_range(0, GRADE_TOP);
      endcase
      return g;
   endfunction

   function automatic void queue_op(logic op, int key, logic hg, int g);
      pending_ops.push_back('{op: op, key: skt_pkg::KEY_W'(key), has_grade: hg,
                              grade: skt_pkg::GRADE_W'(g)});
   endfunction

   // directed opening: empty table, key extremes, bin edges, repeats, absents
   task automatic build_directed();
      queue_op(skt_pkg::OP_DELETE, 0, 1'b1, 500);            // delete on empty table
      queue_op(skt_pkg::OP_INSERT, 0, 1'b1, 0);              // lowest key, bin 0
      queue_op(skt_pkg::OP_INSERT, KEY_TOP, 1'b1, GRADE_TOP); // highest key, bin 9
      queue_op(skt_pkg::OP_INSERT, 0, 1'b1, 700);            // repeat key: found only
      queue_op(skt_pkg::OP_INSERT, 50, 1'b0, 300);           // no grade, no bin change
      queue_op(skt_pkg::OP_INSERT, 51, 1'b1, 999);           // 9.99 -> bin 9
      queue_op(skt_pkg::OP_INSERT, 52, 1'b1, 100);           // lower edge of bin 1
      queue_op(skt_pkg::OP_INSERT, 53, 1'b1, 99);            // upper edge of bin 0
      queue_op(skt_pkg::OP_INSERT, 49, 1'b1, 900);           // goes in front of 50
      queue_op(skt_pkg::OP_INSERT, KEY_TOP - 1, 1'b1, 899);  // just below the top key
      queue_op(skt_pkg::OP_DELETE, 50, 1'b1, 200);           // ungraded record
      queue_op(skt_pkg::OP_DELETE, 0, 1'b0, 0);              // bin 0 down
      queue_op(skt_pkg::OP_DELETE, 7, 1'b0, 0);              // absent key
      queue_op(skt_pkg::OP_DELETE, KEY_TOP, 1'b0, 1);        // top key, bin 9 down
      queue_op(skt_pkg::OP_DELETE, KEY_TOP, 1'b1, 1000);     // same key again: absent
      queue_op(skt_pkg::OP_INSERT, 1 << (skt_pkg::KEY_W - 1), 1'b1, 512);
      queue_op(skt_pkg::OP_INSERT, (1 << (skt_pkg::KEY_W - 1)) - 1, 1'b1, 511);
   endtask

   // episodes over a window of a shared key pool; the insert share swings
   // between fill-up and drain so the table runs both full and empty
   task automatic build_random();
      int made, base, span, ins_pct, len;
      logic [skt_pkg::KEY_W-1:0] k;
      logic op;
      key_pool[0] = '0;
      key_pool[1] = skt_pkg::KEY_W'(KEY_TOP);
      key_pool[2] = skt_pkg::KEY_W'(1);
      key_pool[3] = skt_pkg::KEY_W'(KEY_TOP - 1);
      for (int i = 4; i < POOL_SIZE; i++) begin
         if ($urandom_range(0, 2) == 0 && key_pool[i-1] < skt_pkg::KEY_W'(KEY_TOP))
            key_pool[i] = key_pool[i-1] + 1'b1;   // neighbors stress the compare
         else
            key_pool[i] = skt_pkg::KEY_W'($urandom_range(0, KEY_TOP));
      end
      made = 0;
      while (made < RANDOM_OPS) begin
         base = $urandom_range(0, POOL_SIZE - 1);
         case ($urandom_range(0, 2))
            0: begin span = POOL_SIZE; ins_pct = 90; end
            1: begin span = POOL_SIZE; ins_pct = 10; end
            default: begin
               span    = $urandom_range(4, POOL_SIZE);
               ins_pct = $urandom_range(20, 80);
            end
         endcase
         len = $urandom_range(20, 160);
         for (int j = 0; j < len && made < RANDOM_OPS; j++) begin
            if ($urandom_range(0, 99) < 5) begin
               // noise: any key, any command
               op = $urandom_range(0, 1) ? skt_pkg::OP_DELETE : skt_pkg::OP_INSERT;
               k  = skt_pkg::KEY_W'($urandom_range(0, KEY_TOP));
            end else begin
               op = ($urandom_range(0, 99) < ins_pct) ? skt_pkg::OP_INSERT
                                                       : skt_pkg::OP_DELETE;
               k  = key_pool[(base + $urandom_range(0, span - 1)) % POOL_SIZE];
            end
            queue_op(op, int'(k), $urandom_range(0, 3) != 0, pick_grade());
            made++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: presents queued commands in bursts, changes inputs on the
   // falling edge; a command stays up until it is taken
   // ------------------------------------------------------------------
   int           burst_left = 1;
   int           gap_left   = 0;
   table_op_type drive_op;

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            drive_op = pending_ops.pop_front();
            req_op        <= drive_op.op;
            req_key       <= drive_op.key;
            req_has_grade <= drive_op.has_grade;
            req_grade     <= drive_op.grade;
            start         <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 4);
                  2: gap_left = $urandom_range(5, 40);
                  default: gap_left = $urandom_range(41, 150);
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks a response before predicting a command taken on the
   // same edge, so an overlap of strobe and accept stays in order
   // ------------------------------------------------------------------
   table_rsp_type seen_rsp, want_rsp;

   always @(posedge clock) begin
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            seen_rsp = '{found: rsp_found, table_full: rsp_table_full,
                         entry_count: rsp_entry_count, bin_changed: rsp_bin_changed,
                         bin_index: rsp_bin_index, bin_count: rsp_bin_count};
            if (expected_rsp.size() == 0) begin
               flag_error($sformatf("response with nothing outstanding: %p", seen_rsp));
            end else begin
               want_rsp = expected_rsp.pop_front();
               n_checked++;
               if (seen_rsp.found !== want_rsp.found
                   || seen_rsp.table_full !== want_rsp.table_full
                   || seen_rsp.entry_count !== want_rsp.entry_count
                   || seen_rsp.bin_changed !== want_rsp.bin_changed
                   || seen_rsp.bin_index !== want_rsp.bin_index
                   || seen_rsp.bin_count !== want_rsp.bin_count)
                  flag_error($sformatf("response %0d\n   expected %p\n   actual   %p",
                                       n_checked, want_rsp, seen_rsp));
            end
         end
         if (start && !busy)
            expected_rsp.push_back(predict_table_op('{op: req_op, key: req_key,
                                   has_grade: req_has_grade, grade: req_grade}));
         // watchdog: any accepted transaction or response restarts the count
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: build stimulus, reset, run until drained, report
   // ------------------------------------------------------------------
   bit timed_out;

   initial begin
      held_count = 0;
      foreach (grade_hist[i]) grade_hist[i] = 0;
      build_directed();
      build_random();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      timed_out = 1'b0;
      while (!timed_out
             && (pending_ops.size() != 0 || start || expected_rsp.size() != 0)) begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
      if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clock);

      if (timed_out)
         $display("Watchdog: %0d cycles without a transaction, %0d commands unsent",
                  WATCHDOG_LIMIT, pending_ops.size());
      else if (expected_rsp.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_rsp.size()));

      $display("Covered %0d inserts (%0d repeats, %0d refused when full), %0d deletes",
               n_inserts, n_repeats, n_refused, n_deletes);
      $display("%0d absent deletes, %0d responses checked, %0d bin updates, peak %0d of %0d",
               n_absent, n_checked, n_bin_moves, peak_count, DEPTH);
      if (!timed_out && error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
